[src/bzv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bzv_pkg;

    localparam int NUM_ZONES_DEF  = 4;
    localparam int COORD_BITS_DEF = 9;

    localparam int FIELD_W   = 9;
    localparam int AREA_W    = 2 * FIELD_W;
    localparam int SIG_W     = 3;
    localparam int AGE_W     = 8;
    localparam int VOTE_W    = 8;
    localparam int WEIGHT_W  = 32;
    localparam int MS_W      = 16;
    localparam int SCORE_W   = 9;
    localparam int OVS_W     = 7;
    localparam int DSUM_W    = 6;

    localparam int QUEUE_DEPTH = 2;

    localparam int MIN_AGE       = 2;
    localparam int MIN_SIDE      = 5;
    localparam int MIN_AREA      = 45;
    localparam int MAX_ASPECT    = 3;
    localparam int ZONE_TOL      = 20;
    localparam int MIN_SCORE     = 20;
    localparam int CONFIRM_SOLID = 3;
    localparam int CONFIRM_SOFT  = 5;
    localparam int VOTE_MARGIN   = 2;
    localparam int INSIDE_BASE   = 200;
    localparam int PCT           = 100;

    localparam int TARGET_RESET = 1;
    localparam int BUDGET_RESET = 900;
    localparam int GIVEUP_RESET = 350;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BLOB  = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        HOW_CONFIRMED = 2'd0,
        HOW_BUDGET    = 2'd1,
        HOW_GAVEUP    = 2'd2
    } how_t;

    typedef struct packed {
        kind_t               kind;
        logic [FIELD_W-1:0]  cx;
        logic [FIELD_W-1:0]  cy;
        logic [FIELD_W-1:0]  bw;
        logic [FIELD_W-1:0]  bh;
        logic [AREA_W-1:0]   area;
    } op_t;

endpackage

`default_nettype wire

[src/bzv_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bzv_front
    import bzv_pkg::*;
(
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [SIG_W-1:0]   signature,
    input  wire logic [AGE_W-1:0]   age,
    input  wire logic [FIELD_W-1:0] center_x,
    input  wire logic [FIELD_W-1:0] center_y,
    input  wire logic [FIELD_W-1:0] blob_width,
    input  wire logic [FIELD_W-1:0] blob_height,
    input  wire logic [SIG_W-1:0]   target,
    input  wire logic               q_ready,
    output logic                    push,
    output op_t                     push_op
);

    logic [AREA_W-1:0]    area;
    logic [FIELD_W+1:0]   bw3;
    logic [FIELD_W+1:0]   bh3;
    logic                 pass;
    kind_t                k;

    always_comb
    begin
        k    = kind_t'(kind);
        area = AREA_W'(blob_width) * AREA_W'(blob_height);
        bw3  = (FIELD_W + 2)'(blob_width) * (FIELD_W + 2)'(MAX_ASPECT);
        bh3  = (FIELD_W + 2)'(blob_height) * (FIELD_W + 2)'(MAX_ASPECT);
        pass = (signature == target)
            && (age >= AGE_W'(MIN_AGE))
            && (blob_width >= FIELD_W'(MIN_SIDE))
            && (blob_height >= FIELD_W'(MIN_SIDE))
            && (area >= AREA_W'(MIN_AREA))
            && ((FIELD_W + 2)'(blob_width) <= bh3)
            && ((FIELD_W + 2)'(blob_height) <= bw3);

        push_op.kind = k;
        push_op.cx   = center_x;
        push_op.cy   = center_y;
        push_op.bw   = blob_width;
        push_op.bh   = blob_height;
        push_op.area = area;
    end

    assign in_ready = q_ready;
    // drop blobs that fail the filters here; they change nothing downstream
    assign push = in_valid && q_ready && ((k != KIND_BLOB) || pass);

endmodule

`default_nettype wire

[src/bzv_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bzv_fifo
    import bzv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       din,
    output logic      ready,
    input  wire logic pop,
    output op_t       dout,
    output logic      valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    op_t           mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign ready = (count_reg != CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= din;
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/bzv_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bzv_back
    import bzv_pkg::*;
#(
    parameter int NUM_ZONES  = NUM_ZONES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_valid,
    input  op_t                                         q_op,
    output logic                                        q_pop,
    input  wire logic [MS_W-1:0]                        budget,
    input  wire logic [MS_W-1:0]                        giveup,
    input  wire logic [NUM_ZONES-1:0][4*COORD_BITS-1:0] zone_box,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        zone_found,
    output logic [1:0]                                  zone,
    output logic [1:0]                                  how
);

    localparam int CB    = COORD_BITS;
    localparam int SW    = ((CB > FIELD_W) ? CB : FIELD_W) + 2;
    localparam int ZAW   = 2 * CB;
    localparam int CMPW  = (ZAW > AREA_W) ? ZAW : AREA_W;
    localparam int NUM_W = AREA_W + OVS_W;
    localparam int ZW    = $clog2(NUM_ZONES);
    localparam int QCW   = $clog2(OVS_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEO,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_SCORE,
        ST_VOTE,
        ST_LEAD,
        ST_RUN,
        ST_DECIDE
    } state_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [ZW-1:0]         zidx_reg;
    how_t                  mode_reg;

    logic [VOTE_W-1:0]     vote_reg   [NUM_ZONES];
    logic [WEIGHT_W-1:0]   weight_reg [NUM_ZONES];
    logic                  solid_reg  [NUM_ZONES];
    logic                  seen_reg;
    logic [MS_W-1:0]       elapsed_reg;
    logic                  active_reg;
    logic [AREA_W-1:0]     fba_reg;
    logic [ZW-1:0]         fbz_reg;
    logic [SCORE_W-1:0]    fbs_reg;

    logic                  inside_reg;
    logic                  near_reg;
    logic                  degen_reg;
    logic                  ovpos_reg;
    logic [DSUM_W-1:0]     dsum_reg;
    logic [FIELD_W-1:0]    ow_reg;
    logic [FIELD_W-1:0]    oh_reg;
    logic [CB-1:0]         zw_reg;
    logic [CB-1:0]         zh_reg;
    logic [AREA_W-1:0]     ov_reg;
    logic [ZAW-1:0]        zarea_reg;
    logic [AREA_W-1:0]     ref_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [OVS_W-1:0]      q_reg;
    logic [QCW-1:0]        qcnt_reg;
    logic [SCORE_W-1:0]    best_reg;
    logic [ZW-1:0]         bz_reg;

    logic [ZW-1:0]         lead_reg;
    logic [VOTE_W-1:0]     lv_reg;
    logic [WEIGHT_W-1:0]   lw_reg;
    logic                  ls_reg;
    logic [VOTE_W-1:0]     rv_reg;
    logic                  have_run_reg;

    logic                  out_valid_reg;
    logic                  found_reg;
    logic [1:0]            zone_reg;
    how_t                  how_reg;

    // combinational helpers
    logic [4*CB-1:0]       box;
    logic [CB-1:0]         bx0, by0, bx1, by1, zl, zr, zt, zb;
    logic signed [SW-1:0]  zls, zrs, zts, zbs, cxs, cys, hw, hh, l, r, t, b;
    logic signed [SW-1:0]  dx_s, dy_s, mnx, mxx, mny, mxy, ow_s, oh_s;
    logic signed [SW-1:0]  tol_s;
    logic [NUM_W-1:0]      dv;
    logic [SCORE_W-1:0]    pen;
    logic [SCORE_W-1:0]    score;
    logic                  score_win;
    logic [SCORE_W-1:0]    best_fin;
    logic [ZW-1:0]         bz_fin;
    logic                  last;
    logic [VOTE_W-1:0]     v_cur;
    logic [WEIGHT_W-1:0]   w_cur;
    logic                  s_cur;
    logic [WEIGHT_W:0]     w_sum;
    logic [MS_W-1:0]       elapsed_inc;
    logic [VOTE_W-1:0]     need;
    logic                  take_lead;

    always_comb
    begin
        box = zone_box[zidx_reg];
        bx0 = box[CB-1:0];
        by0 = box[2*CB-1:CB];
        bx1 = box[3*CB-1:2*CB];
        by1 = box[4*CB-1:3*CB];
        zl  = (bx0 < bx1) ? bx0 : bx1;
        zr  = (bx0 < bx1) ? bx1 : bx0;
        zt  = (by0 < by1) ? by0 : by1;
        zb  = (by0 < by1) ? by1 : by0;

        zls = $signed(SW'(zl));
        zrs = $signed(SW'(zr));
        zts = $signed(SW'(zt));
        zbs = $signed(SW'(zb));
        cxs = $signed(SW'(op_reg.cx));
        cys = $signed(SW'(op_reg.cy));
        hw  = $signed(SW'(op_reg.bw >> 1));
        hh  = $signed(SW'(op_reg.bh >> 1));
        l   = cxs - hw;
        r   = cxs + hw;
        t   = cys - hh;
        b   = cys + hh;

        if (cxs < zls)
            dx_s = zls - cxs;
        else if (cxs > zrs)
            dx_s = cxs - zrs;
        else
            dx_s = '0;
        if (cys < zts)
            dy_s = zts - cys;
        else if (cys > zbs)
            dy_s = cys - zbs;
        else
            dy_s = '0;
        tol_s = $signed(SW'(ZONE_TOL));

        mnx  = (r < zrs) ? r : zrs;
        mxx  = (l > zls) ? l : zls;
        mny  = (b < zbs) ? b : zbs;
        mxy  = (t > zts) ? t : zts;
        ow_s = mnx - mxx;
        oh_s = mny - mxy;

        dv = NUM_W'(ref_reg) << qcnt_reg;

        pen = SCORE_W'((SCORE_W'(dsum_reg) * SCORE_W'(5)) >> 1);
        if (degen_reg)
            score = '0;
        else if (inside_reg)
            score = SCORE_W'(INSIDE_BASE) + SCORE_W'(q_reg);
        else if (near_reg)
            score = SCORE_W'(INSIDE_BASE - 1) - pen;
        else
            score = SCORE_W'(q_reg);
        score_win = (score > best_reg);
        best_fin  = score_win ? score : best_reg;
        bz_fin    = score_win ? zidx_reg : bz_reg;

        last  = (zidx_reg == ZW'(NUM_ZONES - 1));
        v_cur = vote_reg[zidx_reg];
        w_cur = weight_reg[zidx_reg];
        s_cur = solid_reg[zidx_reg];
        w_sum = (WEIGHT_W + 1)'(w_cur) + (WEIGHT_W + 1)'(fba_reg);

        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        need = ls_reg ? VOTE_W'(CONFIRM_SOLID) : VOTE_W'(CONFIRM_SOFT);
        take_lead = (zidx_reg == '0) || (v_cur > lv_reg)
            || ((v_cur == lv_reg) && (w_cur > lw_reg));
    end

    assign q_pop      = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign zone_found = found_reg;
    assign zone       = zone_reg;
    assign how        = how_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            zidx_reg      <= '0;
            mode_reg      <= HOW_CONFIRMED;
            for (int z = 0; z < NUM_ZONES; z++)
            begin
                vote_reg[z]   <= '0;
                weight_reg[z] <= '0;
                solid_reg[z]  <= 1'b0;
            end
            seen_reg      <= 1'b0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            fba_reg       <= '0;
            fbz_reg       <= '1;
            fbs_reg       <= '0;
            inside_reg    <= 1'b0;
            near_reg      <= 1'b0;
            degen_reg     <= 1'b0;
            ovpos_reg     <= 1'b0;
            dsum_reg      <= '0;
            ow_reg        <= '0;
            oh_reg        <= '0;
            zw_reg        <= '0;
            zh_reg        <= '0;
            ov_reg        <= '0;
            zarea_reg     <= '0;
            ref_reg       <= '0;
            num_reg       <= '0;
            q_reg         <= '0;
            qcnt_reg      <= '0;
            best_reg      <= '0;
            bz_reg        <= '0;
            lead_reg      <= '0;
            lv_reg        <= '0;
            lw_reg        <= '0;
            ls_reg        <= 1'b0;
            rv_reg        <= '0;
            have_run_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            zone_reg      <= '0;
            how_reg       <= HOW_CONFIRMED;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        op_reg <= q_op;
                        unique case (q_op.kind)
                            KIND_START:
                            begin
                                for (int z = 0; z < NUM_ZONES; z++)
                                begin
                                    vote_reg[z]   <= '0;
                                    weight_reg[z] <= '0;
                                    solid_reg[z]  <= 1'b0;
                                end
                                seen_reg    <= 1'b0;
                                elapsed_reg <= '0;
                                fba_reg     <= '0;
                                fbz_reg     <= '1;
                                fbs_reg     <= '0;
                                if (budget == '0)
                                begin
                                    active_reg    <= 1'b0;
                                    out_valid_reg <= 1'b1;
                                    found_reg     <= 1'b0;
                                    zone_reg      <= '0;
                                    how_reg       <= HOW_BUDGET;
                                end
                                else
                                begin
                                    active_reg <= 1'b1;
                                end
                            end
                            KIND_BLOB:
                            begin
                                if (active_reg)
                                begin
                                    zidx_reg  <= '0;
                                    best_reg  <= '0;
                                    bz_reg    <= '0;
                                    state_reg <= ST_GEO;
                                end
                            end
                            KIND_FRAME:
                            begin
                                if (active_reg)
                                begin
                                    if (fba_reg == '0)
                                    begin
                                        if (!seen_reg && (elapsed_reg > giveup))
                                        begin
                                            zidx_reg  <= '0;
                                            mode_reg  <= HOW_GAVEUP;
                                            state_reg <= ST_LEAD;
                                        end
                                    end
                                    else
                                    begin
                                        zidx_reg  <= fbz_reg;
                                        state_reg <= ST_VOTE;
                                    end
                                end
                            end
                            KIND_TICK:
                            begin
                                if (active_reg)
                                begin
                                    elapsed_reg <= elapsed_inc;
                                    if (elapsed_inc >= budget)
                                    begin
                                        zidx_reg  <= '0;
                                        mode_reg  <= HOW_BUDGET;
                                        state_reg <= ST_LEAD;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_GEO:
                begin
                    degen_reg  <= (zr == zl) || (zb == zt);
                    inside_reg <= (dx_s == '0) && (dy_s == '0);
                    near_reg   <= (dx_s <= tol_s) && (dy_s <= tol_s);
                    dsum_reg   <= DSUM_W'(dx_s) + DSUM_W'(dy_s);
                    ovpos_reg  <= (ow_s > $signed(SW'(0))) && (oh_s > $signed(SW'(0)));
                    ow_reg     <= FIELD_W'(ow_s);
                    oh_reg     <= FIELD_W'(oh_s);
                    zw_reg     <= zr - zl;
                    zh_reg     <= zb - zt;
                    state_reg  <= ST_MUL;
                end

                ST_MUL:
                begin
                    ov_reg    <= ovpos_reg ? AREA_W'(ow_reg) * AREA_W'(oh_reg) : '0;
                    zarea_reg <= ZAW'(zw_reg) * ZAW'(zh_reg);
                    state_reg <= ST_PREP;
                end

                ST_PREP:
                begin
                    ref_reg   <= (CMPW'(zarea_reg) < CMPW'(op_reg.area))
                                 ? AREA_W'(zarea_reg) : op_reg.area;
                    num_reg   <= NUM_W'(ov_reg) * NUM_W'(PCT);
                    q_reg     <= '0;
                    qcnt_reg  <= QCW'(OVS_W - 1);
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    // overlap never exceeds the reference area, so the quotient fits OVS_W bits
                    if (num_reg >= dv)
                    begin
                        num_reg          <= num_reg - dv;
                        q_reg[qcnt_reg]  <= 1'b1;
                    end
                    if (qcnt_reg == '0)
                        state_reg <= ST_SCORE;
                    else
                        qcnt_reg <= qcnt_reg - 1'b1;
                end

                ST_SCORE:
                begin
                    best_reg <= best_fin;
                    bz_reg   <= bz_fin;
                    if (last)
                    begin
                        if ((best_fin >= SCORE_W'(MIN_SCORE)) && (op_reg.area > fba_reg))
                        begin
                            fba_reg <= op_reg.area;
                            fbz_reg <= bz_fin;
                            fbs_reg <= best_fin;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        zidx_reg  <= zidx_reg + 1'b1;
                        state_reg <= ST_GEO;
                    end
                end

                ST_VOTE:
                begin
                    seen_reg <= 1'b1;
                    vote_reg[zidx_reg] <= (v_cur == '1) ? v_cur : v_cur + 1'b1;
                    weight_reg[zidx_reg] <= w_sum[WEIGHT_W] ? '1 : w_sum[WEIGHT_W-1:0];
                    if (fbs_reg >= SCORE_W'(INSIDE_BASE))
                        solid_reg[zidx_reg] <= 1'b1;
                    fba_reg   <= '0;
                    fbz_reg   <= '1;
                    fbs_reg   <= '0;
                    zidx_reg  <= '0;
                    mode_reg  <= HOW_CONFIRMED;
                    state_reg <= ST_LEAD;
                end

                ST_LEAD:
                begin
                    if (take_lead)
                    begin
                        lead_reg <= zidx_reg;
                        lv_reg   <= v_cur;
                        lw_reg   <= w_cur;
                        ls_reg   <= s_cur;
                    end
                    if (last)
                    begin
                        zidx_reg <= '0;
                        if (mode_reg != HOW_CONFIRMED)
                        begin
                            // best evidence: the leader counts only if it has votes
                            active_reg    <= 1'b0;
                            out_valid_reg <= 1'b1;
                            how_reg       <= mode_reg;
                            if (take_lead)
                            begin
                                found_reg <= (v_cur != '0);
                                zone_reg  <= (v_cur != '0) ? 2'(zidx_reg) : '0;
                            end
                            else
                            begin
                                found_reg <= (lv_reg != '0);
                                zone_reg  <= (lv_reg != '0) ? 2'(lead_reg) : '0;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            have_run_reg <= 1'b0;
                            rv_reg       <= '0;
                            state_reg    <= ST_RUN;
                        end
                    end
                    else
                    begin
                        zidx_reg <= zidx_reg + 1'b1;
                    end
                end

                ST_RUN:
                begin
                    if ((zidx_reg != lead_reg) && (!have_run_reg || (v_cur > rv_reg)))
                    begin
                        rv_reg       <= v_cur;
                        have_run_reg <= 1'b1;
                    end
                    if (last)
                        state_reg <= ST_DECIDE;
                    else
                        zidx_reg <= zidx_reg + 1'b1;
                end

                ST_DECIDE:
                begin
                    if ((lv_reg >= need)
                        && ((VOTE_W + 1)'(lv_reg)
                            >= (VOTE_W + 1)'(rv_reg) + (VOTE_W + 1)'(VOTE_MARGIN)))
                    begin
                        active_reg    <= 1'b0;
                        out_valid_reg <= 1'b1;
                        found_reg     <= 1'b1;
                        zone_reg      <= 2'(lead_reg);
                        how_reg       <= HOW_CONFIRMED;
                    end
                    state_reg <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/blob_zone_vote_detector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Blob zone vote detector. Commands (start scan, blob report, end of frame,
// millisecond tick) enter on the input channel; a front stage filters blob
// reports by signature, age, side, area and aspect and drops the rejects, and
// a two-entry queue feeds the back end, which scores, votes and reports at
// most one result per command on the output channel. The back end takes one
// command at a time: a blob report that passes the filters while a scan runs
// goes through the per-zone scoring sequence (geometry, multiply, prepare,
// divide, score), whose overlap percentage comes from a 7-step restoring
// divider; a dropped blob report never reaches the back end; an end of frame
// runs the vote update and the leader and runner-up scans; a tick adds a
// leader scan when the budget runs out. A result that waits on the output
// holds the back end until it is accepted.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// (index 0 target signature, 1..NUM_ZONES zone boxes, then scan budget and
// give-up time in ms); the user must write them only while the block is idle,
// as the block itself does not enforce it.
module blob_zone_vote_detector
    import bzv_pkg::*;
#(
    parameter int NUM_ZONES  = NUM_ZONES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            kind,
    input  wire logic [SIG_W-1:0]                      signature,
    input  wire logic [AGE_W-1:0]                      age,
    input  wire logic [FIELD_W-1:0]                    center_x,
    input  wire logic [FIELD_W-1:0]                    center_y,
    input  wire logic [FIELD_W-1:0]                    blob_width,
    input  wire logic [FIELD_W-1:0]                    blob_height,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       zone_found,
    output logic [1:0]                                 zone,
    output logic [1:0]                                 how,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [$clog2(NUM_ZONES+3)-1:0]        cfg_index,
    input  wire logic [4*COORD_BITS-1:0]               cfg_data
);

    localparam int IW         = $clog2(NUM_ZONES + 3);
    localparam int BOX_W      = 4 * COORD_BITS;
    localparam int IDX_TARGET = 0;
    localparam int IDX_BUDGET = NUM_ZONES + 1;
    localparam int IDX_GIVEUP = NUM_ZONES + 2;

    logic [SIG_W-1:0]                  target_reg;
    logic [NUM_ZONES-1:0][BOX_W-1:0]   box_reg;
    logic [MS_W-1:0]                   budget_reg;
    logic [MS_W-1:0]                   giveup_reg;

    logic  q_ready;
    logic  push;
    op_t   push_op;
    logic  q_valid;
    op_t   q_op;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= SIG_W'(TARGET_RESET);
            box_reg    <= '0;
            budget_reg <= MS_W'(BUDGET_RESET);
            giveup_reg <= MS_W'(GIVEUP_RESET);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == IW'(IDX_TARGET))
                target_reg <= cfg_data[SIG_W-1:0];
            if (cfg_index == IW'(IDX_BUDGET))
                budget_reg <= cfg_data[MS_W-1:0];
            if (cfg_index == IW'(IDX_GIVEUP))
                giveup_reg <= cfg_data[MS_W-1:0];
            for (int z = 0; z < NUM_ZONES; z++)
            begin
                if (cfg_index == IW'(z + 1))
                    box_reg[z] <= cfg_data;
            end
        end
    end

    bzv_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .signature   (signature),
        .age         (age),
        .center_x    (center_x),
        .center_y    (center_y),
        .blob_width  (blob_width),
        .blob_height (blob_height),
        .target      (target_reg),
        .q_ready     (q_ready),
        .push        (push),
        .push_op     (push_op)
    );

    bzv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_op),
        .ready (q_ready),
        .pop   (q_pop),
        .dout  (q_op),
        .valid (q_valid)
    );

    bzv_back #(
        .NUM_ZONES  (NUM_ZONES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_pop      (q_pop),
        .budget     (budget_reg),
        .giveup     (giveup_reg),
        .zone_box   (box_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .zone_found (zone_found),
        .zone       (zone),
        .how        (how)
    );

`ifndef NO_ASSERTIONS
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zone_found |-> zone == '0)
        else $error("zone not zero when no zone found");

    a_confirm_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && how == HOW_CONFIRMED |-> zone_found)
        else $error("confirmed result without a zone");

    a_how_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (how == HOW_CONFIRMED || how == HOW_BUDGET || how == HOW_GAVEUP))
        else $error("bad result code");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_blob_zone_vote_detector.sv]
`timescale 1ns / 1ps

module tb_blob_zone_vote_detector;
    import bzv_pkg::*;

    localparam int ZONES      = 4;
    localparam int REG_TARGET = 0;
    localparam int REG_ZONE0  = 1;
    localparam int REG_BUDGET = ZONES + 1;
    localparam int REG_GIVEUP = ZONES + 2;
    localparam int REG_SPARE  = ZONES + 3;
    localparam int NO_ZONE    = 7;
    localparam int SETTLE     = 200;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic       found;
        logic [1:0] zone;
        how_t       how;
    } verdict_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_TICK;
    logic [2:0]  signature = '0;
    logic [7:0]  age = '0;
    logic [8:0]  center_x = '0;
    logic [8:0]  center_y = '0;
    logic [8:0]  blob_width = '0;
    logic [8:0]  blob_height = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        zone_found;
    logic [1:0]  zone;
    logic [1:0]  how;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [35:0] cfg_data = '0;

    // model state
    logic [2:0]  m_target;
    logic [35:0] m_box [ZONES];
    logic [15:0] m_budget;
    logic [15:0] m_giveup;
    logic [7:0]  m_votes [ZONES];
    logic [31:0] m_weight [ZONES];
    logic        m_solid [ZONES];
    logic        m_seen;
    logic [15:0] m_elapsed;
    logic        m_active;
    logic [17:0] m_fb_area;
    logic [2:0]  m_fb_zone;
    logic [8:0]  m_fb_score;

    verdict_t pending_verdicts [$];
    int errors = 0;
    int items_sent = 0;
    int cycles = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 0;

    blob_zone_vote_detector DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .signature(signature), .age(age),
        .center_x(center_x), .center_y(center_y),
        .blob_width(blob_width), .blob_height(blob_height),
        .out_valid(out_valid), .out_ready(out_ready),
        .zone_found(zone_found), .zone(zone), .how(how),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------- predictor ----------------

    function automatic void clear_frame_best();
        m_fb_area = '0;
        m_fb_zone = NO_ZONE;
        m_fb_score = '0;
    endfunction

    function automatic void clear_scan();
        for (int z = 0; z < ZONES; z++)
        begin
            m_votes[z] = '0;
            m_weight[z] = '0;
            m_solid[z] = 1'b0;
        end
        m_seen = 1'b0;
        m_elapsed = '0;
        clear_frame_best();
    endfunction

    function automatic void model_reset();
        m_target = 3'd1;
        for (int z = 0; z < ZONES; z++)
            m_box[z] = '0;
        m_budget = 16'd900;
        m_giveup = 16'd350;
        m_active = 1'b0;
        clear_scan();
    endfunction

    function automatic void model_write(int idx, logic [35:0] data);
        if (idx == REG_TARGET)
            m_target = data[2:0];
        else if (idx >= REG_ZONE0 && idx < REG_ZONE0 + ZONES)
            m_box[idx - REG_ZONE0] = data;
        else if (idx == REG_BUDGET)
            m_budget = data[15:0];
        else if (idx == REG_GIVEUP)
            m_giveup = data[15:0];
    endfunction

    function automatic void push_verdict(int z, how_t h);
        verdict_t v;
        v.found = (z >= 0);
        v.zone = (z >= 0) ? z[1:0] : 2'd0;
        v.how = h;
        pending_verdicts.push_back(v);
    endfunction

    function automatic int strongest_zone();
        int best = -1;
        for (int z = 0; z < ZONES; z++)
        begin
            if (m_votes[z] == 0)
                continue;
            if (best < 0 || m_votes[z] > m_votes[best] ||
                (m_votes[z] == m_votes[best] && m_weight[z] > m_weight[best]))
                best = z;
        end
        return best;
    endfunction

    function automatic int zone_score(int l, int t, int r, int b, int cx, int cy,
                                      longint area, logic [35:0] box);
        int f0 = int'(box[8:0]);
        int f1 = int'(box[17:9]);
        int f2 = int'(box[26:18]);
        int f3 = int'(box[35:27]);
        int zl = (f0 < f2) ? f0 : f2;
        int zr = (f0 > f2) ? f0 : f2;
        int zt = (f1 < f3) ? f1 : f3;
        int zb = (f1 > f3) ? f1 : f3;
        int dx = 0;
        int dy = 0;
        int ow;
        int oh;
        longint zarea;
        longint refa;
        longint ov;
        longint ovs;
        if (zr - zl <= 0 || zb - zt <= 0)
            return 0;
        if (cx < zl) dx = zl - cx; else if (cx > zr) dx = cx - zr;
        if (cy < zt) dy = zt - cy; else if (cy > zb) dy = cy - zb;
        zarea = longint'(zr - zl) * longint'(zb - zt);
        refa = (area < zarea) ? area : zarea;
        ow = ((r < zr) ? r : zr) - ((l > zl) ? l : zl);
        oh = ((b < zb) ? b : zb) - ((t > zt) ? t : zt);
        ov = (ow <= 0 || oh <= 0) ? 0 : longint'(ow) * longint'(oh);
        ovs = (refa > 0) ? (ov * 100) / refa : 0;
        if (dx == 0 && dy == 0)
            return INSIDE_BASE + int'(ovs);
        if (dx <= ZONE_TOL && dy <= ZONE_TOL)
            return INSIDE_BASE - ((dx + dy) * 100) / (2 * ZONE_TOL) - 1;
        return int'(ovs);
    endfunction

    function automatic void score_blob(logic [2:0] s, logic [7:0] a, int cx, int cy,
                                       int bw, int bh);
        longint area = longint'(bw) * bh;
        int best = 0;
        int bz = -1;
        int sc;
        if (s != m_target || a < MIN_AGE || bw < MIN_SIDE || bh < MIN_SIDE)
            return;
        if (area < MIN_AREA || bw * 10 > bh * 30 || bh * 10 > bw * 30)
            return;
        for (int z = 0; z < ZONES; z++)
        begin
            sc = zone_score(cx - bw / 2, cy - bh / 2, cx + bw / 2, cy + bh / 2,
                            cx, cy, area, m_box[z]);
            if (sc > best)
            begin
                best = sc;
                bz = z;
            end
        end
        if (bz < 0 || best < MIN_SCORE)
            return;
        if (area > m_fb_area)
        begin
            m_fb_area = area[17:0];
            m_fb_zone = bz[2:0];
            m_fb_score = best[8:0];
        end
    endfunction

    function automatic void close_frame();
        int fz;
        int lead = 0;
        int run = -1;
        int need;
        int rv;
        longint w;
        if (m_fb_area == 0)
        begin
            if (!m_seen && m_elapsed > m_giveup)
            begin
                m_active = 1'b0;
                push_verdict(strongest_zone(), HOW_GAVEUP);
            end
            return;
        end
        fz = m_fb_zone % ZONES;
        m_seen = 1'b1;
        if (m_votes[fz] < 255)
            m_votes[fz]++;
        w = longint'(m_weight[fz]) + m_fb_area;
        m_weight[fz] = (w > 64'hFFFFFFFF) ? 32'hFFFFFFFF : w[31:0];
        if (m_fb_score >= INSIDE_BASE)
            m_solid[fz] = 1'b1;
        clear_frame_best();
        for (int z = 1; z < ZONES; z++)
            if (m_votes[z] > m_votes[lead] ||
                (m_votes[z] == m_votes[lead] && m_weight[z] > m_weight[lead]))
                lead = z;
        for (int z = 0; z < ZONES; z++)
        begin
            if (z == lead)
                continue;
            if (run < 0 || m_votes[z] > m_votes[run])
                run = z;
        end
        need = m_solid[lead] ? CONFIRM_SOLID : CONFIRM_SOFT;
        rv = (run >= 0) ? m_votes[run] : 0;
        if (m_votes[lead] >= need && m_votes[lead] >= rv + VOTE_MARGIN)
        begin
            m_active = 1'b0;
            push_verdict(lead, HOW_CONFIRMED);
        end
    endfunction

    function automatic void predict_item(kind_t k, logic [2:0] s, logic [7:0] a,
                                         logic [8:0] x, logic [8:0] y,
                                         logic [8:0] w, logic [8:0] h);
        if (k == KIND_START)
        begin
            clear_scan();
            if (m_budget == 0)
            begin
                m_active = 1'b0;
                push_verdict(-1, HOW_BUDGET);
            end
            else
                m_active = 1'b1;
            return;
        end
        if (!m_active)
            return;
        if (k == KIND_BLOB)
            score_blob(s, a, int'(x), int'(y), int'(w), int'(h));
        else if (k == KIND_FRAME)
            close_frame();
        else
        begin
            if (m_elapsed < 16'hFFFF)
                m_elapsed++;
            if (m_elapsed >= m_budget)
            begin
                m_active = 1'b0;
                push_verdict(strongest_zone(), HOW_BUDGET);
            end
        end
    endfunction

    // ---------------- result side ----------------

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // outputs are stable from the falling edge up to the accepting rising edge
    always @(negedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t result expected none actual found %0d zone %0d how %0d",
                         $time, zone_found, zone, how);
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (zone_found !== v.found)
                begin
                    errors++;
                    $display("%0t zone_found expected %0d actual %0d",
                             $time, v.found, zone_found);
                end
                if (zone !== v.zone)
                begin
                    errors++;
                    $display("%0t zone expected %0d actual %0d", $time, v.zone, zone);
                end
                if (how !== v.how)
                begin
                    errors++;
                    $display("%0t how expected %0d actual %0d", $time, v.how, how);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // called at a rising edge; returns at a rising edge
    task automatic send_item(kind_t k, logic [2:0] s, logic [7:0] a, logic [8:0] x,
                             logic [8:0] y, logic [8:0] w, logic [8:0] h);
        in_valid <= 1'b1;
        kind <= k;
        signature <= s;
        age <= a;
        center_x <= x;
        center_y <= y;
        blob_width <= w;
        blob_height <= h;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        predict_item(k, s, a, x, y, w, h);
        items_sent++;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_cmd(kind_t k);
        send_item(k, 3'($urandom), 8'($urandom), 9'($urandom), 9'($urandom),
                  9'($urandom), 9'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [35:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        model_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [35:0] make_box(int x0, int y0, int x1, int y1);
        return {y1[8:0], x1[8:0], y0[8:0], x0[8:0]};
    endfunction

    task automatic send_blob(bit noise);
        logic [35:0] box;
        int z;
        int lo;
        int hi;
        int cx;
        int cy;
        int w;
        int h;
        if (noise)
        begin
            send_cmd(KIND_BLOB);
            return;
        end
        z = $urandom_range(ZONES - 1);
        box = m_box[z];
        lo = (box[8:0] < box[26:18]) ? box[8:0] : box[26:18];
        hi = (box[8:0] < box[26:18]) ? box[26:18] : box[8:0];
        cx = $urandom_range(lo, hi) + $urandom_range(50) - 25;
        lo = (box[17:9] < box[35:27]) ? box[17:9] : box[35:27];
        hi = (box[17:9] < box[35:27]) ? box[35:27] : box[17:9];
        cy = $urandom_range(lo, hi) + $urandom_range(50) - 25;
        cx = (cx < 0) ? 0 : (cx > 511) ? 511 : cx;
        cy = (cy < 0) ? 0 : (cy > 511) ? 511 : cy;
        w = $urandom_range(5, 60);
        h = $urandom_range(5, 60);
        send_item(KIND_BLOB,
                  ($urandom_range(99) < 85) ? m_target : 3'($urandom),
                  ($urandom_range(99) < 90) ? 8'($urandom_range(2, 255))
                                            : 8'($urandom_range(1)),
                  9'(cx), 9'(cy), 9'(w), 9'(h));
    endtask

    task automatic run_scans(int n);
        int goal = items_sent + n;
        while (items_sent < goal)
        begin
            if (!m_active || $urandom_range(99) < 3)
                send_cmd(KIND_START);
            if ($urandom_range(99) < 5)
                send_cmd(kind_t'($urandom_range(3)));
            else
            begin
                repeat ($urandom_range(3))
                    send_blob($urandom_range(99) < 15);
                send_cmd(KIND_FRAME);
                repeat ($urandom_range(2))
                    send_cmd(KIND_TICK);
            end
        end
    endtask

    task automatic random_config();
        int x;
        int y;
        write_reg(REG_TARGET, 36'($urandom_range(1, 7)));
        for (int z = 0; z < ZONES; z++)
        begin
            if ($urandom_range(99) < 25)
                write_reg(REG_ZONE0 + z, 36'({$urandom, $urandom}));
            else
            begin
                x = $urandom_range(400);
                y = $urandom_range(400);
                if ($urandom_range(1))
                    write_reg(REG_ZONE0 + z,
                              make_box(x, y, x + $urandom_range(10, 110),
                                       y + $urandom_range(10, 110)));
                else
                    write_reg(REG_ZONE0 + z,
                              make_box(x + $urandom_range(10, 110),
                                       y + $urandom_range(10, 110), x, y));
            end
        end
        write_reg(REG_BUDGET, 36'($urandom_range(10, 60)));
        write_reg(REG_GIVEUP, 36'($urandom_range(15)));
    endtask

    task automatic test_directed();
        write_reg(REG_TARGET, 1);
        write_reg(REG_ZONE0 + 0, make_box(10, 10, 100, 100));
        write_reg(REG_ZONE0 + 1, make_box(300, 100, 200, 10));
        write_reg(REG_ZONE0 + 2, make_box(50, 200, 50, 300));
        write_reg(REG_ZONE0 + 3, make_box(400, 400, 480, 500));
        write_reg(REG_BUDGET, 900);
        write_reg(REG_GIVEUP, 350);
        write_reg(REG_SPARE, 36'hFFFFFFFFF);
        // ignored while idle
        send_item(KIND_BLOB, 1, 5, 50, 50, 20, 20);
        send_cmd(KIND_FRAME);
        send_cmd(KIND_TICK);
        send_cmd(KIND_START);
        send_item(KIND_BLOB, 1, 5, 50, 50, 20, 20);
        send_item(KIND_BLOB, 2, 5, 250, 50, 30, 30);
        send_item(KIND_BLOB, 1, 1, 250, 50, 30, 30);
        send_item(KIND_BLOB, 1, 5, 250, 50, 4, 30);
        send_item(KIND_BLOB, 1, 5, 250, 50, 5, 8);
        send_item(KIND_BLOB, 1, 5, 250, 50, 30, 9);
        send_item(KIND_BLOB, 1, 255, 115, 50, 24, 24);
        send_item(KIND_BLOB, 1, 9, 50, 250, 20, 20);
        send_item(KIND_BLOB, 7, 255, 511, 511, 511, 511);
        send_item(KIND_BLOB, 0, 0, 0, 0, 0, 0);
        send_cmd(KIND_FRAME);
        send_cmd(KIND_TICK);
        send_cmd(KIND_START);
        repeat (3)
        begin
            send_item(KIND_BLOB, 1, 5, 60, 60, 20, 20);
            send_cmd(KIND_FRAME);
        end
        drain();
        // give up on an empty frame, then a zero and a one millisecond budget
        write_reg(REG_GIVEUP, 0);
        send_cmd(KIND_START);
        send_cmd(KIND_TICK);
        send_cmd(KIND_FRAME);
        drain();
        write_reg(REG_BUDGET, 0);
        send_cmd(KIND_START);
        drain();
        write_reg(REG_BUDGET, 1);
        send_cmd(KIND_START);
        send_cmd(KIND_TICK);
        drain();
    endtask

    task automatic test_sender_light_idle();
        tx_gap_pct = 6;
        rx_stall_pct = 77;
        repeat (2)
        begin
            random_config();
            run_scans(140);
            drain();
        end
    endtask

    task automatic test_receiver_light_idle();
        tx_gap_pct = 77;
        rx_stall_pct = 6;
        repeat (2)
        begin
            random_config();
            run_scans(140);
            drain();
        end
    endtask

    task automatic test_no_idle_extremes();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        random_config();
        write_reg(REG_TARGET, 7);
        write_reg(REG_BUDGET, 16'hFFFF);
        write_reg(REG_GIVEUP, 16'hFFFF);
        run_scans(100);
        drain();
        random_config();
        run_scans(100);
        drain();
    endtask

    task automatic test_pressure();
        random_config();
        write_reg(REG_BUDGET, 3);
        hold_req = 1;
        // short budget: every few ticks a result piles up behind the held output
        while (hold_req)
        begin
            send_cmd(KIND_START);
            repeat (3) send_cmd(KIND_TICK);
        end
        drain();
        random_config();
        run_scans(30);
        // pause until every result is in, then carry on with the same scan
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        run_scans(30);
        drain();
    endtask

    initial
    begin
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sender_light_idle();
        test_receiver_light_idle();
        test_no_idle_extremes();
        test_pressure();
        drain();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
